/* design/tcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_pkg - shared types and constants of the crossing frequency meter
// Widths, register indexes, reset values and the queue entry type.
// ----------------------------------------------------------------------------
package tcm_pkg;

    localparam int SAMPLE_W  = 11;
    localparam int TIME_W    = 32;
    localparam int THR_W     = 10;
    localparam int WLEN_W    = 10;
    localparam int FREQ_W    = 24;
    localparam int AMP_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 10'd522;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 10'd512;

    localparam int MAX_WINDOW_DEF = 512;
    localparam int MIN_WINDOW     = 2;

    // Polarity codes; the fourth code behaves as undetermined.
    localparam logic [1:0] MODE_UNDET = 2'd0;
    localparam logic [1:0] MODE_POS   = 2'd1;
    localparam logic [1:0] MODE_NEG   = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -11'sd1024;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 11'sd1023;

    // Frequency numerator: 1e6 us/s times 256 for Q8.
    localparam int                 DIV_STEPS  = 28;
    localparam logic [DIV_STEPS-1:0] FREQ_NUM = 28'd256000000;
    localparam logic [FREQ_W-1:0]  FREQ_SAT   = 24'hFFFFFF;
    // Periods below this value give a quotient above FREQ_SAT.
    localparam logic [TIME_W-1:0]  SAT_PERIOD = 32'd16;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                crossing;
        logic                freq_valid;
        logic [TIME_W-1:0]   period_us;
        logic                window_last;
        logic [AMP_W-1:0]    amplitude;
    } tcm_desc_t;

endpackage

/* design/tcm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_front - sample classifier
// Tracks polarity, edge timing and window extremes; emits one entry per item.
// ----------------------------------------------------------------------------
module tcm_front #(
    parameter int MAX_WINDOW = tcm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tcm_pkg::CFG_DAT_W-1:0]           cfg_data,
    input  logic                                    in_fire,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0]     in_sample,
    input  logic [tcm_pkg::TIME_W-1:0]              in_time,
    output tcm_pkg::tcm_desc_t                      desc
);

    localparam int CNT_W = $clog2(MAX_WINDOW);
    localparam int CMP_W = ((CNT_W + 1) > tcm_pkg::WLEN_W) ? (CNT_W + 1) : tcm_pkg::WLEN_W;
    localparam int EXT_W = tcm_pkg::SAMPLE_W + 1;

    logic [tcm_pkg::THR_W-1:0]          thr_reg;
    logic [tcm_pkg::WLEN_W-1:0]         wlen_reg;
    logic signed [tcm_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic [1:0]                         mode_reg, mode_next;
    logic [tcm_pkg::TIME_W-1:0]         edge_time_reg, edge_time_next;
    logic                               edge_seen_reg, edge_seen_next;
    logic signed [tcm_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic signed [tcm_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;

    logic signed [EXT_W-1:0] thr_pos, thr_neg, cur_x, prev_x, amp_x;
    logic                    rise, fall, counted, last;
    logic [CMP_W-1:0]        wl_ext, len_eff, cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= tcm_pkg::THR_RESET;
            wlen_reg <= tcm_pkg::WLEN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tcm_pkg::REG_CROSS_THRESHOLD: thr_reg  <= cfg_data[tcm_pkg::THR_W-1:0];
                tcm_pkg::REG_WINDOW_LENGTH:   wlen_reg <= cfg_data[tcm_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        thr_pos = EXT_W'($signed({1'b0, thr_reg}));
        thr_neg = -thr_pos;
        cur_x   = EXT_W'(in_sample);
        prev_x  = EXT_W'(prev_reg);
        rise    = (prev_x <= thr_pos) && (cur_x > thr_pos);
        fall    = (prev_x >= thr_neg) && (cur_x < thr_neg);

        wl_ext = CMP_W'(wlen_reg);
        if (wl_ext < CMP_W'(tcm_pkg::MIN_WINDOW)) begin
            len_eff = CMP_W'(tcm_pkg::MIN_WINDOW);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            len_eff = CMP_W'(MAX_WINDOW);
        end else begin
            len_eff = wl_ext;
        end
        cnt_inc = CMP_W'(cnt_reg) + CMP_W'(1);
        last    = cnt_inc >= len_eff;

        mode_next      = mode_reg;
        edge_time_next = edge_time_reg;
        edge_seen_next = edge_seen_reg;
        counted        = 1'b0;

        desc             = '0;
        desc.window_last = last;

        if (cnt_reg == '0) begin
            edge_seen_next = 1'b0;
        end else begin
            case (mode_reg)
                tcm_pkg::MODE_POS: counted = rise;
                tcm_pkg::MODE_NEG: counted = fall;
                default: begin
                    if (rise) begin
                        mode_next = tcm_pkg::MODE_POS;
                        counted   = 1'b1;
                    end else if (fall) begin
                        mode_next = tcm_pkg::MODE_NEG;
                    end
                end
            endcase
            if (counted) begin
                if (edge_seen_reg) begin
                    desc.freq_valid = 1'b1;
                    desc.period_us  = in_time - edge_time_reg;
                end
                edge_time_next = in_time;
                edge_seen_next = 1'b1;
            end
        end
        desc.crossing = counted;

        max_next = (in_sample > max_reg) ? in_sample : max_reg;
        min_next = (in_sample < min_reg) ? in_sample : min_reg;
        amp_x    = EXT_W'(max_next) - EXT_W'(min_next);
        if (last) begin
            desc.amplitude = amp_x[tcm_pkg::AMP_W-1:0];
            max_next       = tcm_pkg::SAMPLE_MIN;
            min_next       = tcm_pkg::SAMPLE_MAX;
            cnt_next       = '0;
        end else begin
            cnt_next = cnt_inc[CNT_W-1:0];
        end
        prev_next = in_sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            mode_reg      <= tcm_pkg::MODE_UNDET;
            edge_time_reg <= '0;
            edge_seen_reg <= 1'b0;
            max_reg       <= tcm_pkg::SAMPLE_MIN;
            min_reg       <= tcm_pkg::SAMPLE_MAX;
            cnt_reg       <= '0;
        end else if (in_fire) begin
            prev_reg      <= prev_next;
            mode_reg      <= mode_next;
            edge_time_reg <= edge_time_next;
            edge_seen_reg <= edge_seen_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

/* design/tcm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_queue - short entry queue
// First-word fall-through queue between the classifier and the divider side.
// ----------------------------------------------------------------------------
module tcm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tcm_pkg::tcm_desc_t push_data,
    output logic               full,
    input  logic               pop,
    output tcm_pkg::tcm_desc_t pop_data,
    output logic               empty
);

    localparam int AW = $clog2(tcm_pkg::QUEUE_DEPTH);

    tcm_pkg::tcm_desc_t mem_reg [tcm_pkg::QUEUE_DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        count_reg;

    assign full     = count_reg == (AW+1)'(tcm_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

/* design/tcm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_back - frequency divider and result register
// Restoring divide of the Q8 numerator by the period, one bit per cycle.
// ----------------------------------------------------------------------------
module tcm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  tcm_pkg::tcm_desc_t              q_data,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tcm_pkg::tcm_desc_t              m_desc,
    output logic [tcm_pkg::FREQ_W-1:0]      m_freq
);

    localparam int STEP_W = $clog2(tcm_pkg::DIV_STEPS);
    localparam int NUM_W  = tcm_pkg::DIV_STEPS;
    localparam int TW     = tcm_pkg::TIME_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    tcm_pkg::tcm_desc_t          work_reg, work_next;
    tcm_pkg::tcm_desc_t          out_desc_reg, out_desc_next;
    logic [tcm_pkg::FREQ_W-1:0]  freq_reg, freq_next;
    logic [tcm_pkg::FREQ_W-1:0]  out_freq_reg, out_freq_next;
    logic [TW-1:0]               rem_reg, rem_next;
    logic [NUM_W-1:0]            num_reg, num_next;
    logic [NUM_W-1:0]            quo_reg, quo_next;

    logic [TW:0] trial;
    logic        fits;

    assign m_valid = out_valid_reg;
    assign m_desc  = out_desc_reg;
    assign m_freq  = out_freq_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        work_next      = work_reg;
        out_desc_next  = out_desc_reg;
        freq_next      = freq_reg;
        out_freq_next  = out_freq_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        q_pop          = 1'b0;

        trial = {rem_reg, num_reg[NUM_W-1]};
        fits  = trial >= {1'b0, work_reg.period_us};

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    work_next = q_data;
                    if (q_data.freq_valid && (q_data.period_us >= tcm_pkg::SAT_PERIOD)) begin
                        rem_next   = '0;
                        num_next   = tcm_pkg::FREQ_NUM;
                        quo_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end else begin
                        freq_next  = q_data.freq_valid ? tcm_pkg::FREQ_SAT : '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                rem_next = fits ? TW'(trial - {1'b0, work_reg.period_us}) : trial[TW-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                quo_next = {quo_reg[NUM_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(tcm_pkg::DIV_STEPS - 1)) begin
                    freq_next  = quo_next[tcm_pkg::FREQ_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_desc_next  = work_reg;
                    out_freq_next  = freq_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        out_desc_reg <= out_desc_next;
        freq_reg     <= freq_next;
        out_freq_reg <= out_freq_next;
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
    end

endmodule

/* design/threshold_crossing_freq_amplitude_meter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_crossing_freq_amplitude_meter_top - crossing frequency meter
// Measures crossing frequency and per-window peak-to-peak amplitude.
// ----------------------------------------------------------------------------
// Each input item is a signed sample with its microsecond timestamp, and each
// one yields exactly one result item, in order. The classifier takes one
// item per cycle as long as its four-entry queue has room; the divider side
// handles one item at a time and pops the next only after the last result
// is handed to the output register. An item with no measured period gives
// zero, a period below 16 us saturates, and any other period is computed
// by the 28-step restoring divider that forms 256000000 / period one
// quotient bit per cycle. Configuration (threshold, window length) is to
// be written through the cfg channel only while the block is idle; the
// block does not enforce this, and cfg_ready is always high.
module threshold_crossing_freq_amplitude_meter_top #(
    parameter int MAX_WINDOW = tcm_pkg::MAX_WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcm_pkg::CFG_DAT_W-1:0]    cfg_data,

    // Sample input.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata from bit 0: sample[10:0], time_us[42:11], zero pad [47:43].
    input  logic [47:0]                      s_tdata,

    // Result output.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata from bit 0: period_us[31:0], freq_hz_q8[55:32],
    // amplitude[66:56], zero pad [71:67].
    output logic [71:0]                      m_tdata,
    // m_tuser from bit 0: crossing, freq_valid.
    output logic [1:0]                       m_tuser,
    // m_tlast: window_last, set on the final sample of a window.
    output logic                             m_tlast
);

    tcm_pkg::tcm_desc_t          front_desc;
    tcm_pkg::tcm_desc_t          q_data;
    tcm_pkg::tcm_desc_t          out_desc;
    logic [tcm_pkg::FREQ_W-1:0]  out_freq;
    logic                        q_full, q_empty, q_pop, in_fire;

    // Configuration writes are taken at any time.
    assign cfg_ready = 1'b1;

    // The classifier stalls only when the queue is full.
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    tcm_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_sample ($signed(s_tdata[tcm_pkg::SAMPLE_W-1:0])),
        .in_time   (s_tdata[tcm_pkg::SAMPLE_W +: tcm_pkg::TIME_W]),
        .desc      (front_desc)
    );

    tcm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    tcm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_desc  (out_desc),
        .m_freq  (out_freq)
    );

    // Pack the result item onto the stream.
    assign m_tdata = {5'b0, out_desc.amplitude, out_freq, out_desc.period_us};
    assign m_tuser = {out_desc.freq_valid, out_desc.crossing};
    assign m_tlast = out_desc.window_last;

    // A measured period only comes with a counted crossing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("freq_valid without crossing");

    // Amplitude is reported only on the last sample of a window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[66:56] == '0)
        else $error("amplitude outside window end");

    // Without a measured period both period and frequency read zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[31:0] == '0) && (m_tdata[55:32] == '0))
        else $error("period or frequency set without freq_valid");

    // Short periods saturate the frequency.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] && (m_tdata[31:0] < tcm_pkg::SAT_PERIOD)
        |-> m_tdata[55:32] == tcm_pkg::FREQ_SAT)
        else $error("short period not saturated");

endmodule
